@@ rtl/murmur2a_stream_hash32_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the MurmurHash2A stream hash
// Shared macros for the concurrent checks of the hash block.
// ----------------------------------------------------------------------------
`ifndef MURMUR2A_STREAM_HASH32_DEFINES_SVH
`define MURMUR2A_STREAM_HASH32_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM2A_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mm2a check failed");

// The consequent must hold in the cycle after the antecedent.
`define MM2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mm2a check failed");

`endif

@@ rtl/mm2a_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2A package
// Constants and widths of the MurmurHash2A 32-bit stream hash.
// ----------------------------------------------------------------------------
package mm2a_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned FILL_W  = 2;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [WORD_W-1:0]  MUL_CONST    = 32'h5bd1e995;
    localparam int unsigned        MIX_SHIFT    = 24;
    localparam int unsigned        FIN_SHIFT_A  = 13;
    localparam int unsigned        FIN_SHIFT_B  = 15;
    localparam logic [COUNT_W-1:0] MAX_COUNT    = 3'd4;

endpackage

@@ rtl/murmur2a_stream_hash32.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2A 32-bit stream hash
// Incremental hash over a byte message delivered up to four bytes at a time.
// ----------------------------------------------------------------------------
// Each input transaction carries up to four little-endian bytes, a byte count
// and tlast. One 32-bit multiplier by the Murmur constant is shared by all
// mixing steps and the finalizer, so the input is held while it works: a
// transaction that completes no 4-byte block leaves the block ready for another,
// one that completes a block waits for the block mix, and a final one waits
// for any block mix, the tail mix, the length mix and the finalizer before the
// hash lands in the output register, and further while that register holds an
// unaccepted hash. The seed is taken at the first transaction of each message.
`include "murmur2a_stream_hash32_defines.svh"

module murmur2a_stream_hash32
    import mm2a_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel: seed.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [WORD_W-1:0]      cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_bytes[31:0], byte_count[34:32], zeros
    input  logic                   s_tlast,
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // hash[31:0]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_K1,
        ST_MIX_K2,
        ST_MIX_H,
        ST_FIN_M,
        ST_FIN_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_BLOCK,
        SEL_TAIL,
        SEL_LENGTH
    } mix_sel_t;

    state_t              state_reg, state_next;
    mix_sel_t            sel_reg, sel_next;
    logic [WORD_W-1:0]   seed_reg, seed_next;
    logic [WORD_W-1:0]   hash_reg, hash_next;
    logic [WORD_W-1:0]   k_reg, k_next;
    logic [WORD_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WORD_W-1:0]   len_reg, len_next;
    logic                in_msg_reg, in_msg_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;

    logic                  in_accept;
    logic [WORD_W-1:0]     in_data;
    logic [COUNT_W-1:0]    in_count_raw;
    logic [COUNT_W-1:0]    in_count;
    logic [WORD_W-1:0]     byte_mask;
    logic [WORD_W-1:0]     hash_base;
    logic [WORD_W-1:0]     tail_base;
    logic [FILL_W-1:0]     fill_base;
    logic [WORD_W-1:0]     len_base;
    logic [2*WORD_W-1:0]   merged;
    logic [COUNT_W-1:0]    fill_sum;
    logic                  word_done;
    logic [WORD_W-1:0]     mul_a;
    logic [WORD_W-1:0]     mul_p;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_accept    = s_tvalid && s_tready;
    assign in_data      = s_tdata[WORD_W-1:0];
    assign in_count_raw = s_tdata[WORD_W+COUNT_W-1:WORD_W];
    assign in_count     = (in_count_raw > MAX_COUNT) ? MAX_COUNT : in_count_raw;
    assign out_free     = !out_valid_reg || m_tready;

    always_comb
    begin
        case (in_count)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    end

    assign hash_base = in_msg_reg ? hash_reg : seed_reg;
    assign tail_base = in_msg_reg ? tail_reg : '0;
    assign fill_base = in_msg_reg ? fill_reg : '0;
    assign len_base  = in_msg_reg ? len_reg  : '0;

    assign merged    = {{WORD_W{1'b0}}, tail_base}
                     | ({{WORD_W{1'b0}}, in_data & byte_mask} << {fill_base, 3'b000});
    assign fill_sum  = {1'b0, fill_base} + in_count;
    assign word_done = fill_sum[FILL_W];

    // Shared multiplier: every step multiplies by the Murmur constant.
    always_comb
    begin
        case (state_reg)
            ST_MIX_K1: mul_a = k_reg;
            ST_MIX_K2: mul_a = k_reg ^ (k_reg >> MIX_SHIFT);
            ST_MIX_H:  mul_a = hash_reg;
            ST_FIN_M:  mul_a = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
            default:   mul_a = hash_reg;
        endcase
    end

    assign mul_p = mul_a * MUL_CONST;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        seed_next      = seed_reg;
        hash_next      = hash_reg;
        k_next         = k_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        in_msg_next    = in_msg_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            seed_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    hash_next   = hash_base;
                    len_next    = len_base + {{(WORD_W-COUNT_W){1'b0}}, in_count};
                    fill_next   = fill_sum[FILL_W-1:0];
                    last_next   = s_tlast;
                    in_msg_next = 1'b1;
                    if (word_done)
                    begin
                        k_next     = merged[WORD_W-1:0];
                        tail_next  = merged[2*WORD_W-1:WORD_W];
                        sel_next   = SEL_BLOCK;
                        state_next = ST_MIX_K1;
                    end
                    else
                    begin
                        tail_next = merged[WORD_W-1:0];
                        if (s_tlast)
                        begin
                            k_next     = merged[WORD_W-1:0];
                            sel_next   = SEL_TAIL;
                            state_next = ST_MIX_K1;
                        end
                    end
                end
            end
            ST_MIX_K1:
            begin
                k_next     = mul_p;
                state_next = ST_MIX_K2;
            end
            ST_MIX_K2:
            begin
                k_next     = mul_p;
                state_next = ST_MIX_H;
            end
            ST_MIX_H:
            begin
                hash_next = mul_p ^ k_reg;
                case (sel_reg)
                    SEL_BLOCK:
                    begin
                        if (last_reg)
                        begin
                            k_next     = tail_reg;
                            sel_next   = SEL_TAIL;
                            state_next = ST_MIX_K1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    SEL_TAIL:
                    begin
                        k_next     = len_reg;
                        sel_next   = SEL_LENGTH;
                        state_next = ST_MIX_K1;
                    end
                    default:
                    begin
                        state_next = ST_FIN_M;
                    end
                endcase
            end
            ST_FIN_M:
            begin
                hash_next  = mul_p;
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                if (out_free)
                begin
                    out_data_next  = hash_reg ^ (hash_reg >> FIN_SHIFT_B);
                    out_valid_next = 1'b1;
                    hash_next      = hash_reg ^ (hash_reg >> FIN_SHIFT_B);
                    tail_next      = '0;
                    fill_next      = '0;
                    len_next       = '0;
                    in_msg_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_BLOCK;
            seed_reg      <= '0;
            hash_reg      <= '0;
            k_reg         <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            in_msg_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            k_reg         <= k_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            in_msg_reg    <= in_msg_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // A final transaction always starts a mixing pass.
    `MM2A_ASSERT_NEXT(a_last_starts_mix, clk, rst_n, in_accept && s_tlast,
        state_reg == ST_MIX_K1)
    // A transaction that completes no block and is not final keeps the block ready.
    `MM2A_ASSERT_NEXT(a_partial_stays_idle, clk, rst_n, in_accept && !s_tlast && !word_done,
        state_reg == ST_IDLE && in_msg_reg)
    // The length mix is always followed by the finalizer multiply.
    `MM2A_ASSERT_NEXT(a_length_then_fin, clk, rst_n,
        state_reg == ST_MIX_H && sel_reg == SEL_LENGTH, state_reg == ST_FIN_M)
    // Once the output register is free, the finished hash is presented.
    `MM2A_ASSERT_NEXT(a_fin_delivers, clk, rst_n, state_reg == ST_FIN_OUT && out_free,
        out_valid_reg && state_reg == ST_IDLE && !in_msg_reg)

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MurmurHash2A 32-bit stream hash
// Messages are fed as byte transactions of up to four bytes. Each accepted
// transaction is run through a local model of the incremental hash, and every
// finished message leaves one predicted hash. The output stream is compared
// in order against those predictions. The tests cover the seed extremes,
// empty messages, byte counts above four, seed writes inside an open message,
// random messages, a long output hold-off and a final run without idling.
// ----------------------------------------------------------------------------
module tb;
    import mm2a_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 4000;

    typedef struct packed {
        logic               last;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  data;
    } byte_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [WORD_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // data_bytes[31:0], byte_count[34:32], zeros
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // hash[31:0]

    byte_item_t        item_q[$];
    logic [WORD_W-1:0] hash_due_q[$];

    logic [WORD_W-1:0] seed_val;
    logic [WORD_W-1:0] acc_hash;
    logic [WORD_W-1:0] tail_word;
    logic [FILL_W-1:0] tail_fill;
    logic [WORD_W-1:0] msg_len;
    logic              msg_open;

    int unsigned errors = 0;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          hold_req;

    murmur2a_stream_hash32 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] mul_m(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] p;
        p = a * MUL_CONST;
        return p;
    endfunction

    function automatic logic [WORD_W-1:0] mix_in(input logic [WORD_W-1:0] h,
                                                 input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] kk;
        kk = mul_m(k);
        kk = kk ^ (kk >> MIX_SHIFT);
        kk = mul_m(kk);
        return mul_m(h) ^ kk;
    endfunction

    // Advances the local hash state by one accepted transaction.
    task automatic absorb_item(input byte_item_t it);
        int unsigned       n;
        logic [WORD_W-1:0] h;
        n = 32'((it.count > MAX_COUNT) ? MAX_COUNT : it.count);
        if (!msg_open)
        begin
            acc_hash  = seed_val;
            tail_word = '0;
            tail_fill = '0;
            msg_len   = '0;
            msg_open  = 1'b1;
        end
        msg_len = msg_len + n;
        for (int unsigned i = 0; i < n; i++)
        begin
            tail_word = tail_word | ({24'd0, it.data[8*i +: 8]} << (8 * tail_fill));
            tail_fill = tail_fill + 1'b1;
            if (tail_fill == 0)
            begin
                acc_hash  = mix_in(acc_hash, tail_word);
                tail_word = '0;
            end
        end
        if (it.last)
        begin
            h = mix_in(acc_hash, tail_word);
            h = mix_in(h, msg_len);
            h = h ^ (h >> FIN_SHIFT_A);
            h = mul_m(h);
            h = h ^ (h >> FIN_SHIFT_B);
            acc_hash  = h;
            tail_word = '0;
            tail_fill = '0;
            msg_len   = '0;
            msg_open  = 1'b0;
            hash_due_q.insert(hash_due_q.size(), h);
        end
    endtask

    // Input driver: one decision per clock edge, so tvalid is assigned once per step.
    initial
    begin
        byte_item_t  cur;
        int unsigned tx_gap;
        cur       = '0;
        tx_gap    = 0;
        acc_hash  = '0;
        tail_word = '0;
        tail_fill = '0;
        msg_len   = '0;
        msg_open  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
                absorb_item(cur);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (item_q.size() > 0 && tx_idle_en && $urandom_range(0, 5) == 0)
                begin
                    tx_gap = $urandom_range(0, 9);
                    s_tvalid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    cur = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'({cur.count, cur.data});
                    s_tlast  <= cur.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver with random stalls and an on-demand long hold-off.
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hash_due_q.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, actual %08h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = hash_due_q.pop_front();
                if (m_tdata[WORD_W-1:0] !== want)
                begin
                    $display("%0t: hash mismatch, expected %08h, actual %08h",
                             $time, want, m_tdata);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] count,
                             input logic last);
        byte_item_t it;
        it.data  = data;
        it.count = count;
        it.last  = last;
        while (item_q.size() >= 4)
            @(posedge clk);
        item_q.insert(item_q.size(), it);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_q.size() != 0 || s_tvalid || !s_tready || hash_due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_val = value;
    endtask

    task automatic send_random_message(input int unsigned max_items, output int unsigned sent);
        int unsigned n;
        logic [COUNT_W-1:0] c;
        n = $urandom_range(1, max_items);
        sent = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            c = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(5, 7))
                                            : COUNT_W'($urandom_range(0, 4));
            sent++;
            if (i == n - 1 || $urandom_range(0, 19) == 0)
            begin
                send_item($urandom, c, 1'b1);
                break;
            end
            send_item($urandom, c, 1'b0);
        end
    endtask

    task automatic test_seed_extremes();
        write_seed(32'h0000_0000);
        send_item(32'h0000_0000, 3'd0, 1'b1);
        send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
        write_seed(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_item(32'h0000_0000, 3'd4, 1'b1);
    endtask

    task automatic test_count_cases();
        send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_item(32'hA5A5_A5A5, 3'd5, 1'b0);
        send_item(32'h5A5A_5A5A, 3'd6, 1'b1);
        send_item(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_item(32'hFFFF_FF00, 3'd3, 1'b1);
        send_item(32'h1234_5678, 3'd0, 1'b0);
        send_item(32'h9ABC_DEF0, 3'd2, 1'b0);
        send_item(32'h0F0F_0F0F, 3'd3, 1'b0);
        send_item(32'hF0F0_F0F0, 3'd4, 1'b0);
        send_item(32'h0000_0000, 3'd0, 1'b1);
    endtask

    task automatic test_seed_mid_message();
        write_seed(32'h1357_9BDF);
        send_item(32'hDEAD_BEEF, 3'd3, 1'b0);
        send_item(32'hCAFE_F00D, 3'd4, 1'b0);
        write_seed(32'h2468_ACE0);
        send_item(32'h0102_0304, 3'd2, 1'b1);
        send_item(32'h0506_0708, 3'd4, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned total;
        int unsigned k;
        logic [WORD_W-1:0] s;
        for (int unsigned phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 3))
                0: s = 32'h0000_0000;
                1: s = 32'hFFFF_FFFF;
                default: s = $urandom;
            endcase
            write_seed(s);
            total = 0;
            while (total < 100)
            begin
                send_random_message(8, k);
                total += k;
            end
        end
    endtask

    task automatic test_output_hold_off();
        write_seed($urandom);
        hold_req = 1'b1;
        for (int unsigned i = 0; i < 30; i++)
            send_item($urandom, COUNT_W'($urandom_range(0, 4)), 1'b1);
    endtask

    task automatic test_no_idle();
        int unsigned total;
        int unsigned k;
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_seed($urandom);
        total = 0;
        while (total < 140)
        begin
            send_random_message(6, k);
            total += k;
        end
    endtask

    initial
    begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req   = 1'b0;
        seed_val   = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_seed_extremes();
        test_count_cases();
        test_seed_mid_message();
        test_random_messages();
        test_output_hold_off();
        test_no_idle();
        wait_idle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
